@@ rtl/core/dit_pkg.sv @@
// shared types and constants for the dns identifier translation table
package dit_pkg;

    localparam int ID_W      = 16;
    localparam int NETIF_W   = 8;
    localparam int TAG_W     = 16;
    localparam int RND_W     = 7;
    localparam int VERDICT_W = 2;

    localparam int DEF_TABLE_DEPTH = 512;
    localparam int DEF_TAG_BITS    = 16;

    localparam logic [VERDICT_W-1:0] VERDICT_QUERY = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_MATCH = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_DROP  = 2'd2;

    // classified header waiting for the table
    typedef struct packed {
        logic               is_response;
        logic [ID_W-1:0]    ident_in;
        logic [ID_W-1:0]    remote_id;
        logic [NETIF_W-1:0] netif_in;
        logic [TAG_W-1:0]   client_tag;
    } t_work;

endpackage

@@ rtl/core/dit_hdr_if.sv @@
// header channel carrying one dns header beat
interface dit_hdr_if
    import dit_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               is_response;
    logic [ID_W-1:0]    ident_in;
    logic [NETIF_W-1:0] netif_in;
    logic [TAG_W-1:0]   client_tag;
    logic [RND_W-1:0]   random_high;

    modport source (
        output valid, is_response, ident_in, netif_in, client_tag, random_high,
        input  ready
    );
    modport sink (
        input  valid, is_response, ident_in, netif_in, client_tag, random_high,
        output ready
    );
endinterface

@@ rtl/core/dit_res_if.sv @@
// result channel carrying one translation result beat
interface dit_res_if
    import dit_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [VERDICT_W-1:0] verdict;
    logic [ID_W-1:0]      ident_out;
    logic [NETIF_W-1:0]   netif_out;
    logic [TAG_W-1:0]     client_tag_out;

    modport source (
        output valid, verdict, ident_out, netif_out, client_tag_out,
        input  ready
    );
    modport sink (
        input  valid, verdict, ident_out, netif_out, client_tag_out,
        output ready
    );
endinterface

@@ rtl/core/dit_front.sv @@
// front end: accepts headers, assigns query slots, queues work for the table
module dit_front
    import dit_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dit_hdr_if.sink     i_hdr,
    input  logic        i_init_done,
    input  logic        i_pop,
    output logic        o_q_valid,
    output t_work       o_q_work
);
    localparam int IDX_W = $clog2(TABLE_DEPTH);

    logic [IDX_W-1:0] r_alloc, n_alloc;
    t_work            r_q [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt, n_cnt;
    logic             w_accept;
    t_work            w_work;

    assign i_hdr.ready = (r_cnt != 2'd2) && i_init_done;
    assign w_accept    = i_hdr.valid && i_hdr.ready;
    assign o_q_valid   = (r_cnt != 2'd0);
    assign o_q_work    = r_q[r_rp];

    always_comb begin
        w_work.is_response = i_hdr.is_response;
        w_work.ident_in    = i_hdr.ident_in;
        // remote id: random bits above the slot index, upper bits dropped
        w_work.remote_id   = ID_W'({i_hdr.random_high, r_alloc});
        w_work.netif_in    = i_hdr.netif_in;
        w_work.client_tag  = i_hdr.client_tag;
    end

    always_comb begin
        n_alloc = r_alloc;
        if (w_accept && !i_hdr.is_response) begin
            n_alloc = r_alloc + 1'b1;
        end
        n_cnt = r_cnt;
        if (w_accept && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!w_accept && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc <= '0;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_cnt   <= 2'd0;
        end else begin
            r_alloc <= n_alloc;
            r_cnt   <= n_cnt;
            if (w_accept) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_q[r_wp] <= w_work;
        end
    end

endmodule

@@ rtl/core/dit_back.sv @@
// back end: table memories, valid clearing pass, lookup and result register
module dit_back
    import dit_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int TAG_BITS    = DEF_TAG_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_work       i_q_work,
    output logic        o_pop,
    output logic        o_init_done,
    dit_res_if.source   o_res
);
    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int SAVED_W = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_CMP  = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]    remote_id;
        logic [ID_W-1:0]    local_id;
        logic [NETIF_W-1:0] netif;
        logic [SAVED_W-1:0] tag;
    } t_entry;

    t_entry r_mem  [TABLE_DEPTH];
    logic   r_vmem [TABLE_DEPTH];

    logic                 r_state, n_state;
    logic                 r_clr_busy;
    logic [IDX_W-1:0]     r_clr_idx;
    t_entry               r_rd_entry;
    logic                 r_rd_valid;
    t_work                r_cur;
    logic [IDX_W-1:0]     r_cur_slot;

    logic                 r_out_vld;
    logic [VERDICT_W-1:0] r_verdict;
    logic [ID_W-1:0]      r_ident;
    logic [NETIF_W-1:0]   r_netif;
    logic [TAG_W-1:0]     r_tag;

    logic                 w_out_free;
    logic [IDX_W-1:0]     w_slot;
    logic                 w_hit;
    logic                 w_load;
    logic [VERDICT_W-1:0] w_verdict;
    logic [ID_W-1:0]      w_ident;
    logic [NETIF_W-1:0]   w_netif;
    logic [TAG_W-1:0]     w_tag;
    logic                 w_mem_we;
    t_entry               w_mem_wd;
    logic                 w_v_we;
    logic [IDX_W-1:0]     w_v_addr;
    logic                 w_v_wd;

    assign o_init_done = !r_clr_busy;
    assign w_out_free  = !r_out_vld || o_res.ready;
    assign o_pop       = (r_state == ST_IDLE) && !r_clr_busy && i_q_valid && w_out_free;
    assign w_slot      = i_q_work.is_response ? i_q_work.ident_in[IDX_W-1:0]
                                              : i_q_work.remote_id[IDX_W-1:0];
    assign w_hit       = r_rd_valid && (r_rd_entry.remote_id == r_cur.ident_in);

    always_comb begin
        n_state   = r_state;
        w_load    = 1'b0;
        w_verdict = VERDICT_QUERY;
        w_ident   = '0;
        w_netif   = '0;
        w_tag     = '0;
        w_mem_we  = 1'b0;
        w_mem_wd.remote_id = i_q_work.remote_id;
        w_mem_wd.local_id  = i_q_work.ident_in;
        w_mem_wd.netif     = i_q_work.netif_in;
        w_mem_wd.tag       = i_q_work.client_tag[SAVED_W-1:0];
        w_v_we    = 1'b0;
        w_v_addr  = w_slot;
        w_v_wd    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    if (i_q_work.is_response) begin
                        n_state = ST_CMP;
                    end else begin
                        w_mem_we  = 1'b1;
                        w_v_we    = 1'b1;
                        w_v_wd    = 1'b1;
                        w_load    = 1'b1;
                        w_verdict = VERDICT_QUERY;
                        w_ident   = i_q_work.remote_id;
                    end
                end
            end
            ST_CMP: begin
                n_state = ST_IDLE;
                w_load  = 1'b1;
                if (w_hit) begin
                    w_v_we    = 1'b1;
                    w_v_addr  = r_cur_slot;
                    w_v_wd    = 1'b0;
                    w_verdict = VERDICT_MATCH;
                    w_ident   = r_rd_entry.local_id;
                    w_netif   = r_rd_entry.netif;
                    w_tag     = TAG_W'(r_rd_entry.tag);
                end else begin
                    w_verdict = VERDICT_DROP;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // clearing pass owns the valid store until done
        if (r_clr_busy) begin
            w_v_we   = 1'b1;
            w_v_addr = r_clr_idx;
            w_v_wd   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_slot] <= w_mem_wd;
        end
        r_rd_entry <= r_mem[w_slot];
    end

    always_ff @(posedge i_clk) begin
        if (w_v_we) begin
            r_vmem[w_v_addr] <= w_v_wd;
        end
        r_rd_valid <= r_vmem[w_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == IDX_W'(TABLE_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur      <= i_q_work;
            r_cur_slot <= w_slot;
        end
        if (w_load) begin
            r_verdict <= w_verdict;
            r_ident   <= w_ident;
            r_netif   <= w_netif;
            r_tag     <= w_tag;
        end
    end

    assign o_res.valid          = r_out_vld;
    assign o_res.verdict        = r_verdict;
    assign o_res.ident_out      = r_ident;
    assign o_res.netif_out      = r_netif;
    assign o_res.client_tag_out = r_tag;

endmodule

@@ rtl/core/dns_ident_translation_table.sv @@
// top level of the dns transaction identifier translation table
//
// i_hdr takes one dns header beat: qr bit, identifier, interface, client tag
// and random bits. o_res gives one result beat per header: verdict, the
// rewritten identifier and, on a matched response, the stored interface and
// client tag. both channels handshake on valid and ready.
// a query claims the next round-robin slot and returns the remote identifier;
// a response looks up the slot named by its low identifier bits and is
// matched and freed or dropped.
// o_res.valid is registered: it rises once a query is popped from the queue,
// or once a response has been compared in ST_CMP. the table memory is read
// and written through one port per cycle, so queries sustain one beat per
// cycle while o_res is not stalled; no header is popped during ST_CMP.
// a two-entry queue sits between the front end and the table, so headers are
// still taken while a result waits on o_res.
// reset clears control state, then a pass clears the valid store one entry a
// cycle: i_hdr.ready stays low after reset until every entry is cleared.
// when o_res is stalled the result is held and the queue fills, then
// i_hdr.ready drops.
module dns_ident_translation_table
    import dit_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int TAG_BITS    = DEF_TAG_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dit_hdr_if.sink     i_hdr,
    dit_res_if.source   o_res
);
    logic  w_init_done;
    logic  w_pop;
    logic  w_q_valid;
    t_work w_q_work;

    dit_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hdr       (i_hdr),
        .i_init_done (w_init_done),
        .i_pop       (w_pop),
        .o_q_valid   (w_q_valid),
        .o_q_work    (w_q_work)
    );

    dit_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_work    (w_q_work),
        .o_pop       (w_pop),
        .o_init_done (w_init_done),
        .o_res       (o_res)
    );

endmodule
